>>> rtl/core/bad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bad_pkg: shared types, constants and tables of the bearing block
// Coordinate widths, the pipeline word carried between search steps and the
// Q2.62 sine and cosine tables that the degree tests use.
// ----------------------------------------------------------------------------
package bad_pkg;

   localparam int COORD_BITS     = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int BEARING_BITS   = 9;

   // Binary search over the whole degrees 0..89 of one quadrant
   localparam int SEARCH_BITS    = 7;
   localparam int SEARCH_STEPS   = SEARCH_BITS;
   localparam int STEP_IDX_BITS  = $clog2(SEARCH_BITS);
   localparam int TAB_DEPTH      = 2 ** SEARCH_BITS;
   localparam logic [SEARCH_BITS-1:0] LAST_DEGREE = SEARCH_BITS'(89);

   // Table words split into two halves for the partial products
   localparam int HALF_W  = 32;
   localparam int PROD_W  = COORD_BITS + HALF_W;
   localparam int DIFF_W  = PROD_W + 1;
   localparam int TOTAL_W = DIFF_W + HALF_W + 1;

   localparam logic [BEARING_BITS-1:0] BASE_UP    = BEARING_BITS'(0);
   localparam logic [BEARING_BITS-1:0] BASE_RIGHT = BEARING_BITS'(90);
   localparam logic [BEARING_BITS-1:0] BASE_DOWN  = BEARING_BITS'(180);
   localparam logic [BEARING_BITS-1:0] BASE_LEFT  = BEARING_BITS'(270);
   localparam logic [BEARING_BITS-1:0] MAX_BEARING = BEARING_BITS'(359);

   localparam logic [COORD_BITS-1:0] CENTRE_RESET = COORD_BITS'(32767);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_CENTRE_X = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CENTRE_Y = CSR_INDEX_BITS'(1);

   typedef enum logic [1:0] {
      QUAD_UP    = 2'd0,
      QUAD_RIGHT = 2'd1,
      QUAD_DOWN  = 2'd2,
      QUAD_LEFT  = 2'd3
   } quad_type;

   typedef struct packed {
      logic [COORD_BITS-1:0]  a;
      logic [COORD_BITS-1:0]  b;
      logic [SEARCH_BITS-1:0] r;
      quad_type               quad;
      logic                   degen;
   } item_type;

   // Q2.62 tables
   localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C234;
   localparam logic [63:0] ONE_Q62 = 64'h4000000000000000;
   localparam int SERIES_TERMS = 24;

   typedef logic [63:0] q62_tab_type [0:TAB_DEPTH-1];

   function automatic logic [63:0] qmul(input logic [63:0] p, input logic [63:0] q);
      logic [127:0] prod;
      prod = {64'd0, p} * {64'd0, q};
      return prod[125:62];
   endfunction

   function automatic logic [63:0] deg_to_q62(input int k);
      logic [63:0] kk;
      kk = 64'(k);
      return (PI_Q62 / 64'd180) * kk + ((PI_Q62 % 64'd180) * kk) / 64'd180;
   endfunction

   function automatic logic [63:0] series_sin(input int k);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] s;
      int          n;
      int          div;
      x    = deg_to_q62(k);
      x2   = qmul(x, x);
      term = x;
      s    = x;
      for (n = 1; n < SERIES_TERMS; n++) begin
         div  = (2 * n) * (2 * n + 1);
         term = qmul(term, x2) / 64'(div);
         if ((n & 1) != 0) s = s - term;
         else s = s + term;
      end
      return s;
   endfunction

   function automatic logic [63:0] series_cos(input int k);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] c;
      int          n;
      int          div;
      x    = deg_to_q62(k);
      x2   = qmul(x, x);
      term = ONE_Q62;
      c    = ONE_Q62;
      for (n = 1; n < SERIES_TERMS; n++) begin
         div  = (2 * n - 1) * (2 * n);
         term = qmul(term, x2) / 64'(div);
         if ((n & 1) != 0) c = c - term;
         else c = c + term;
      end
      return c;
   endfunction

   // Test k passes when b*C[k] >= a*S[k]. Above 45 degrees the roles of
   // sine and cosine swap; at 45 both weights are one, giving a <= b.
   function automatic q62_tab_type build_tab(input logic want_cos);
      q62_tab_type t;
      int          k;
      for (k = 0; k < TAB_DEPTH; k++) begin
         if (k == 0) t[k] = want_cos ? ONE_Q62 : 64'd0;
         else if (k < 45) t[k] = want_cos ? series_cos(k) : series_sin(k);
         else if (k == 45) t[k] = ONE_Q62;
         else if (k < 90) t[k] = want_cos ? series_sin(90 - k) : series_cos(90 - k);
         else t[k] = 64'd0;
      end
      return t;
   endfunction

   localparam q62_tab_type S_TAB = build_tab(1'b0);
   localparam q62_tab_type C_TAB = build_tab(1'b1);

endpackage

>>> rtl/core/bad_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bad_ifs: channel interfaces of the bearing block
// Point requests, bearing responses and centre register writes.
// ----------------------------------------------------------------------------
interface bad_req_if;
   import bad_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] point_x;
   logic [COORD_BITS-1:0] point_y;
   modport source (output valid, output point_x, output point_y, input ready);
   modport sink (input valid, input point_x, input point_y, output ready);
endinterface

interface bad_rsp_if;
   import bad_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [BEARING_BITS-1:0] bearing;
   logic                    degenerate;
   modport source (output valid, output bearing, output degenerate, input ready);
   modport sink (input valid, input bearing, input degenerate, output ready);
endinterface

interface bad_csr_if;
   import bad_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [COORD_BITS-1:0]     data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/bad_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bad_step: one binary search step of the degree search
// Tries one more result bit; the exact cross test runs over two stages,
// low table halves first, then high halves and the sign of the sum.
// ----------------------------------------------------------------------------
module bad_step (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [bad_pkg::STEP_IDX_BITS-1:0] step_bit,
   input  bad_pkg::item_type                 in_item,
   input  logic                              in_valid,
   output logic                              in_ready,
   output bad_pkg::item_type                 out_item,
   output logic                              out_valid,
   input  logic                              out_ready
);
   import bad_pkg::*;

   logic                    x_valid_ff;
   item_type                x_item_ff;
   logic [SEARCH_BITS-1:0]  x_cand_ff;
   logic [DIFF_W-1:0]       x_lo_ff;
   logic                    y_valid_ff;
   item_type                y_item_ff;

   logic                    x_ready;
   logic                    y_ready;
   logic [SEARCH_BITS-1:0]  cand_in;
   logic [PROD_W-1:0]       bc_lo;
   logic [PROD_W-1:0]       as_lo;
   logic [DIFF_W-1:0]       x_lo_in;
   logic [PROD_W-1:0]       bc_hi;
   logic [PROD_W-1:0]       as_hi;
   logic [DIFF_W-1:0]       hi_diff;
   logic [TOTAL_W-1:0]      total;
   logic                    hit;
   item_type                y_item_in;

   assign y_ready  = !y_valid_ff || out_ready;
   assign x_ready  = !x_valid_ff || y_ready;
   assign in_ready = x_ready;

   // low halves
   always_comb begin
      cand_in = in_item.r | (SEARCH_BITS'(1) << step_bit);
      bc_lo   = PROD_W'(in_item.b) * PROD_W'(C_TAB[cand_in][HALF_W-1:0]);
      as_lo   = PROD_W'(in_item.a) * PROD_W'(S_TAB[cand_in][HALF_W-1:0]);
      x_lo_in = DIFF_W'(bc_lo) - DIFF_W'(as_lo);
   end

   // high halves, weighted by 2^32, plus the low difference
   always_comb begin
      bc_hi   = PROD_W'(x_item_ff.b) * PROD_W'(C_TAB[x_cand_ff][63:HALF_W]);
      as_hi   = PROD_W'(x_item_ff.a) * PROD_W'(S_TAB[x_cand_ff][63:HALF_W]);
      hi_diff = DIFF_W'(bc_hi) - DIFF_W'(as_hi);
      total   = {hi_diff[DIFF_W-1], hi_diff, {HALF_W{1'b0}}}
              + {{(TOTAL_W-DIFF_W){x_lo_ff[DIFF_W-1]}}, x_lo_ff};
      hit     = !total[TOTAL_W-1] && (x_cand_ff <= LAST_DEGREE);
      y_item_in = x_item_ff;
      if (hit) y_item_in.r = x_cand_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_valid_ff <= 1'b0;
         y_valid_ff <= 1'b0;
      end else begin
         if (x_ready) x_valid_ff <= in_valid;
         if (y_ready) y_valid_ff <= x_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (x_ready && in_valid) begin
         x_item_ff <= in_item;
         x_cand_ff <= cand_in;
         x_lo_ff   <= x_lo_in;
      end
      if (y_ready && x_valid_ff) begin
         y_item_ff <= y_item_in;
      end
   end

   assign out_item  = y_item_ff;
   assign out_valid = y_valid_ff;

endmodule

>>> rtl/core/bearing_angle_degrees.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bearing_angle_degrees: whole-degree bearing of a point around a centre
// Pipelined exact degree search: quadrant fold, seven search steps, output.
// ----------------------------------------------------------------------------
// Usage
//   req_chan carries one point word (point_x, point_y). rsp_chan returns one
//   word per point: bearing, the floor of the clockwise angle from up
//   (smaller y is up), 0..359, and degenerate, set when the point equals
//   the centre (bearing then 0).
//   csr_chan writes the centre: index 0 is centre_x, index 1 is centre_y,
//   other indexes are dropped. It is always ready. Write only while idle.
// Structure and throughput
//   One stage folds the point into a quadrant, seven binary search steps
//   take two stages each (each step tests one degree against the Q2.62
//   sine/cosine tables, low table halves then high halves), and one stage
//   forms the bearing.
//   One word per cycle while rsp_chan is ready; no feedback between words.
// Reset and stall
//   Reset clears all stage valid bits and sets the centre to 32767, 32767.
//   A stalled receiver holds the output word; each stage advances when its
//   successor is free, so bubbles still close up and req_chan stays ready
//   until the whole pipeline is full.
// ----------------------------------------------------------------------------
module bearing_angle_degrees (
   input logic  clock,
   input logic  reset,
   bad_req_if.sink   req_chan,
   bad_rsp_if.source rsp_chan,
   bad_csr_if.sink   csr_chan
);
   import bad_pkg::*;

   // centre registers
   logic [COORD_BITS-1:0] centre_x_ff;
   logic [COORD_BITS-1:0] centre_y_ff;

   // quadrant fold stage
   logic                  s0_valid_ff;
   item_type              s0_item_ff;
   item_type              s0_item_in;
   logic                  s0_ready;

   // search step chain
   item_type              step_item  [0:SEARCH_STEPS];
   logic                  step_valid [0:SEARCH_STEPS];
   logic                  step_ready [0:SEARCH_STEPS];

   // output stage
   logic                    out_valid_ff;
   logic [BEARING_BITS-1:0] bearing_ff;
   logic                    degen_ff;
   logic [BEARING_BITS-1:0] bearing_in;
   logic [BEARING_BITS-1:0] base;
   logic                    out_ready;

   logic                  req_fire;

   // ---------------------------------------------------------------
   // Configuration: always ready, unknown indexes dropped
   // ---------------------------------------------------------------
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         centre_x_ff <= CENTRE_RESET;
         centre_y_ff <= CENTRE_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_CENTRE_X: centre_x_ff <= csr_chan.data;
            CSR_CENTRE_Y: centre_y_ff <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Quadrant fold: a is the distance along the quadrant's start axis,
   // b the distance clockwise from it, so that a > 0 and b >= 0 but at the centre.
   // ---------------------------------------------------------------
   always_comb begin
      s0_item_in       = '0;
      s0_item_in.degen = (req_chan.point_x == centre_x_ff)
                      && (req_chan.point_y == centre_y_ff);
      if (req_chan.point_y < centre_y_ff && req_chan.point_x >= centre_x_ff) begin
         s0_item_in.quad = QUAD_UP;
         s0_item_in.a    = centre_y_ff - req_chan.point_y;
         s0_item_in.b    = req_chan.point_x - centre_x_ff;
      end else if (req_chan.point_x > centre_x_ff && req_chan.point_y >= centre_y_ff) begin
         s0_item_in.quad = QUAD_RIGHT;
         s0_item_in.a    = req_chan.point_x - centre_x_ff;
         s0_item_in.b    = req_chan.point_y - centre_y_ff;
      end else if (req_chan.point_y > centre_y_ff && req_chan.point_x <= centre_x_ff) begin
         s0_item_in.quad = QUAD_DOWN;
         s0_item_in.a    = req_chan.point_y - centre_y_ff;
         s0_item_in.b    = centre_x_ff - req_chan.point_x;
      end else begin
         // also the centre itself: a and b are zero, the bearing is forced later
         s0_item_in.quad = QUAD_LEFT;
         s0_item_in.a    = centre_x_ff - req_chan.point_x;
         s0_item_in.b    = centre_y_ff - req_chan.point_y;
      end
   end

   assign s0_ready       = !s0_valid_ff || step_ready[0];
   assign req_chan.ready = s0_ready;
   assign req_fire       = req_chan.valid && s0_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (s0_ready) begin
         s0_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s0_item_ff <= s0_item_in;
      end
   end

   // ---------------------------------------------------------------
   // Search chain: step i decides result bit SEARCH_BITS-1-i
   // ---------------------------------------------------------------
   assign step_item[0]  = s0_item_ff;
   assign step_valid[0] = s0_valid_ff;

   for (genvar i = 0; i < SEARCH_STEPS; i++) begin : g_step
      bad_step u_step (
         .clock     (clock),
         .reset     (reset),
         .step_bit  (STEP_IDX_BITS'(SEARCH_BITS - 1 - i)),
         .in_item   (step_item[i]),
         .in_valid  (step_valid[i]),
         .in_ready  (step_ready[i]),
         .out_item  (step_item[i+1]),
         .out_valid (step_valid[i+1]),
         .out_ready (step_ready[i+1])
      );
   end

   // ---------------------------------------------------------------
   // Output stage: add the quadrant base, force zero for the centre
   // ---------------------------------------------------------------
   assign out_ready                = !out_valid_ff || rsp_chan.ready;
   assign step_ready[SEARCH_STEPS] = out_ready;

   always_comb begin
      case (step_item[SEARCH_STEPS].quad)
         QUAD_UP:    base = BASE_UP;
         QUAD_RIGHT: base = BASE_RIGHT;
         QUAD_DOWN:  base = BASE_DOWN;
         QUAD_LEFT:  base = BASE_LEFT;
         default:    base = BASE_UP;
      endcase
      if (step_item[SEARCH_STEPS].degen) bearing_in = BASE_UP;
      else bearing_in = base + BEARING_BITS'(step_item[SEARCH_STEPS].r);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= step_valid[SEARCH_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && step_valid[SEARCH_STEPS]) begin
         bearing_ff <= bearing_in;
         degen_ff   <= step_item[SEARCH_STEPS].degen;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.bearing    = bearing_ff;
   assign rsp_chan.degenerate = degen_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_bearing_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (bearing_ff <= MAX_BEARING))
      else $error("bearing beyond 359");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && degen_ff) |-> (bearing_ff == BASE_UP))
      else $error("degenerate word with nonzero bearing");

   a_fold_loaded: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s0_valid_ff)
      else $error("accepted point word lost at fold stage");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("response valid right after reset");

endmodule
